// ===== sv/mma_pkg.sv =====
// mma_pkg: shared types, codes and helpers for the Montgomery modular ALU.
// No dependencies; used by mma_ppmul and montgomery_mod_alu_64.
package mma_pkg;

  localparam int unsigned VAL_W = 63;   // operand / result width
  localparam int unsigned WORD_W = 64;  // internal word, R = 2^64
  localparam int unsigned HALF_W = 32;  // partial product slice
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_SUB      = 3'd1,
    MODE_MUL      = 3'd2,
    MODE_TO_MONT  = 3'd3,
    MODE_FROM_MONT = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_MOD_INV  = 2'd1,
    REG_R_SQUARED = 2'd2
  } cfg_reg_t;

  // Four 32x32 partial products of a 64x64 multiply.
  typedef struct packed {
    logic [WORD_W-1:0] p00;  // a_lo * b_lo
    logic [WORD_W-1:0] p01;  // a_lo * b_hi
    logic [WORD_W-1:0] p10;  // a_hi * b_lo
    logic [WORD_W-1:0] p11;  // a_hi * b_hi
  } pp_t;

  // Recombine partial products into the full 128-bit product.
  function automatic logic [2*WORD_W-1:0] pp_sum(input pp_t pp);
    logic [2*WORD_W-1:0] base;
    logic [2*WORD_W-1:0] mid0;
    logic [2*WORD_W-1:0] mid1;
    base = {pp.p11, pp.p00};
    mid0 = {{HALF_W{1'b0}}, pp.p01, {HALF_W{1'b0}}};
    mid1 = {{HALF_W{1'b0}}, pp.p10, {HALF_W{1'b0}}};
    return base + mid0 + mid1;
  endfunction

endpackage

// ===== sv/mma_ppmul.sv =====
// mma_ppmul: one pipeline stage of four registered 32x32 partial products.
// Depends on mma_pkg (pp_t, widths).
module mma_ppmul (
  input  logic                       clk,
  input  logic                       en,
  input  logic [mma_pkg::WORD_W-1:0] op_a,
  input  logic [mma_pkg::WORD_W-1:0] op_b,
  output mma_pkg::pp_t               pp_r
);

  logic [mma_pkg::HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
  mma_pkg::pp_t               pp_nxt;

  assign a_lo = op_a[mma_pkg::HALF_W-1:0];
  assign a_hi = op_a[mma_pkg::WORD_W-1:mma_pkg::HALF_W];
  assign b_lo = op_b[mma_pkg::HALF_W-1:0];
  assign b_hi = op_b[mma_pkg::WORD_W-1:mma_pkg::HALF_W];

  always_comb begin
    pp_nxt.p00 = mma_pkg::WORD_W'(a_lo) * mma_pkg::WORD_W'(b_lo);
    pp_nxt.p01 = mma_pkg::WORD_W'(a_lo) * mma_pkg::WORD_W'(b_hi);
    pp_nxt.p10 = mma_pkg::WORD_W'(a_hi) * mma_pkg::WORD_W'(b_lo);
    pp_nxt.p11 = mma_pkg::WORD_W'(a_hi) * mma_pkg::WORD_W'(b_hi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
    end
  end

endmodule

// ===== sv/montgomery_mod_alu_64.sv =====
// montgomery_mod_alu_64: pipelined modular add/sub/Montgomery product unit, R = 2^64.
// Depends on mma_pkg and mma_ppmul (three instances).
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_mode/a/b         | request in
//   result  | out_valid, out_stall, out_result        | request out
//   config  | cfg_we, cfg_index, cfg_wdata            | write only
//
// Eight register stages; one request per cycle sustained while the result side is not stalled.
// The three 64x64 multiplies (a*b, lo*inv, q*m) each take a partial-product
// stage and a summing stage, which sets the depth.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register
// reset values; payload registers are not reset.
// A stall on the result side while out_valid is high freezes every stage at once, so
// nothing is lost or repeated; in_stall follows it in the same cycle.
module montgomery_mod_alu_64 (
  input  logic                          clk,
  input  logic                          rst_n,
  // input requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_mode,
  input  logic [mma_pkg::VAL_W-1:0]     in_operand_a,
  input  logic [mma_pkg::VAL_W-1:0]     in_operand_b,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mma_pkg::VAL_W-1:0]     out_result,
  // configuration
  input  logic                          cfg_we,
  input  logic [mma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mma_pkg::WORD_W-1:0]    cfg_wdata
);

  localparam int unsigned W = mma_pkg::WORD_W;
  localparam int unsigned V = mma_pkg::VAL_W;
  localparam int unsigned NSTG = 8;

  // ---- configuration registers ----
  logic [V-1:0] modulus_r;
  logic [W-1:0] mod_inverse_r;
  logic [V-1:0] r_squared_r;
  logic [W-1:0] m64;

  assign m64 = {1'b0, modulus_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r     <= V'(1);
      mod_inverse_r <= W'(1);
      r_squared_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mma_pkg::REG_MODULUS:   modulus_r     <= cfg_wdata[V-1:0];
        mma_pkg::REG_MOD_INV:   mod_inverse_r <= cfg_wdata;
        mma_pkg::REG_R_SQUARED: r_squared_r   <= cfg_wdata[V-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // ---- pipeline control: one global advance ----
  logic            adv;
  logic [NSTG:1]   vld_r;

  assign adv       = ~vld_r[NSTG] | ~out_stall;
  assign in_stall  = ~adv;
  assign out_valid = vld_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:1], in_valid};
    end
  end

  // ---- stage 1: operand select and add/sub ----
  logic [W-1:0] a_ext, b_ext;
  logic [W-1:0] b_sel_nxt;
  logic [W-1:0] as_raw, as_fix, as_nxt;
  logic [2:0]   s1_mode_r;
  logic [W-1:0] s1_a_r, s1_b_r, s1_as_r;

  assign a_ext = {1'b0, in_operand_a};
  assign b_ext = {1'b0, in_operand_b};

  always_comb begin
    // mode 4 is REDC(a) = REDC(a * 1)
    unique case (in_mode)
      mma_pkg::MODE_TO_MONT:   b_sel_nxt = {1'b0, r_squared_r};
      mma_pkg::MODE_FROM_MONT: b_sel_nxt = W'(1);
      default:                 b_sel_nxt = b_ext;
    endcase
    // add: r = a + b - m, fix-up a + b; sub: r = a - b, fix-up a - b + m
    if (in_mode == mma_pkg::MODE_SUB) begin
      as_raw = a_ext - b_ext;
      as_fix = a_ext - b_ext + m64;
    end else begin
      as_raw = a_ext + b_ext - m64;
      as_fix = a_ext + b_ext;
    end
    as_nxt = as_raw[W-1] ? as_fix : as_raw;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r <= in_mode;
      s1_a_r    <= a_ext;
      s1_b_r    <= b_sel_nxt;
      s1_as_r   <= as_nxt;
    end
  end

  // side-band carried alongside the arithmetic, stages 2..7
  logic [2:0]   mode_pipe_r [2:NSTG-1];
  logic [W-1:0] as_pipe_r   [2:NSTG-1];
  logic [W-1:0] hi_pipe_r   [4:NSTG-1];

  // ---- stage 2: a * b partial products ----
  mma_pkg::pp_t pp_ab_r;

  mma_ppmul u_mul_ab (
    .clk  (clk),
    .en   (adv),
    .op_a (s1_a_r),
    .op_b (s1_b_r),
    .pp_r (pp_ab_r)
  );

  // ---- stage 3: x = a * b ----
  logic [2*W-1:0] x_nxt;
  logic [W-1:0]   s3_lo_r, s3_hi_r;

  assign x_nxt = mma_pkg::pp_sum(pp_ab_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_lo_r <= x_nxt[W-1:0];
      s3_hi_r <= x_nxt[2*W-1:W];
    end
  end

  // ---- stage 4: lo(x) * inv partial products ----
  mma_pkg::pp_t pp_q_r;

  mma_ppmul u_mul_q (
    .clk  (clk),
    .en   (adv),
    .op_a (s3_lo_r),
    .op_b (mod_inverse_r),
    .pp_r (pp_q_r)
  );

  // ---- stage 5: q = lo(x) * inv mod 2^64 ----
  logic [2*W-1:0] q_full;
  logic [W-1:0]   s5_q_r;

  assign q_full = mma_pkg::pp_sum(pp_q_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_q_r <= q_full[W-1:0];
    end
  end

  // ---- stage 6: q * m partial products ----
  mma_pkg::pp_t pp_t_r;

  mma_ppmul u_mul_t (
    .clk  (clk),
    .en   (adv),
    .op_a (s5_q_r),
    .op_b (m64),
    .pp_r (pp_t_r)
  );

  // ---- stage 7: t = hi(q * m) ----
  logic [2*W-1:0] t_full;
  logic [W-1:0]   s7_t_r;

  assign t_full = mma_pkg::pp_sum(pp_t_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_t_r <= t_full[2*W-1:W];
    end
  end

  // side-band shift
  always_ff @(posedge clk) begin
    if (adv) begin
      mode_pipe_r[2] <= s1_mode_r;
      as_pipe_r[2]   <= s1_as_r;
      for (int i = 3; i <= NSTG-1; i++) begin
        mode_pipe_r[i] <= mode_pipe_r[i-1];
        as_pipe_r[i]   <= as_pipe_r[i-1];
      end
      hi_pipe_r[4] <= s3_hi_r;
      for (int i = 5; i <= NSTG-1; i++) begin
        hi_pipe_r[i] <= hi_pipe_r[i-1];
      end
    end
  end

  // ---- stage 8: REDC correction and result select ----
  logic [W-1:0] y_raw, y_fix, y_sel, res_nxt;
  logic [V-1:0] out_result_r;

  always_comb begin
    y_raw = hi_pipe_r[NSTG-1] - s7_t_r;
    y_fix = hi_pipe_r[NSTG-1] - s7_t_r + m64;
    y_sel = y_raw[W-1] ? y_fix : y_raw;
    unique case (mode_pipe_r[NSTG-1]) inside
      mma_pkg::MODE_ADD,
      mma_pkg::MODE_SUB:       res_nxt = as_pipe_r[NSTG-1];
      mma_pkg::MODE_MUL,
      mma_pkg::MODE_TO_MONT,
      mma_pkg::MODE_FROM_MONT: res_nxt = y_sel;
      default:                 res_nxt = '0;  // unused modes
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= res_nxt[V-1:0];
    end
  end

  assign out_result = out_result_r;

endmodule

// ===== bench/montgomery_mod_alu_64_tb.sv =====
// Self-checking bench for montgomery_mod_alu_64: directed and random requests across several
// modulus settings, each result checked against an in-bench Montgomery predictor.
// Depends on mma_pkg (modes, register indexes, widths) and the montgomery_mod_alu_64 RTL.
module montgomery_mod_alu_64_tb;

  localparam int unsigned VAL_W     = mma_pkg::VAL_W;
  localparam int unsigned WORD_W    = mma_pkg::WORD_W;
  localparam int unsigned CFG_IDX_W = mma_pkg::CFG_IDX_W;

  // Codes the package leaves unnamed: spare modes and the spare register slot
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
  localparam int unsigned DRAIN_CYCLES = 12;   // pipeline is 8 deep
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]       mode;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } alu_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_mode = '0;
  logic [VAL_W-1:0]     in_operand_a = '0;
  logic [VAL_W-1:0]     in_operand_b = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VAL_W-1:0]     out_result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  // Bench copy of the register file, tracked from the write port
  logic [VAL_W-1:0]  mod_m   = VAL_W'(1);
  logic [WORD_W-1:0] mod_inv = WORD_W'(1);
  logic [VAL_W-1:0]  mod_r2  = '0;

  alu_req_t         pending_reqs[$];
  logic [VAL_W-1:0] due_results[$];
  logic [VAL_W-1:0] want;
  int               faults = 0;
  int unsigned      cycle_count = 0;
  int unsigned      burst_odds = 0;     // 0: no idling on either side
  int unsigned      gap_left = 0;
  int unsigned      stall_left = 0;

  montgomery_mod_alu_64 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // REDC on a 128-bit value: hi(x) - hi(q*m) with q = lo(x)*inv, fixed up by +m
  // when the 64-bit difference goes negative. All of it wraps at 2^64.
  function automatic logic [WORD_W-1:0] redc_value(input logic [2*WORD_W-1:0] x);
    logic [WORD_W-1:0]   q;
    logic [2*WORD_W-1:0] qm;
    logic [WORD_W-1:0]   y;
    q  = x[WORD_W-1:0] * mod_inv;
    qm = {64'd0, q} * {65'd0, mod_m};
    y  = x[2*WORD_W-1:WORD_W] - qm[2*WORD_W-1:WORD_W];
    if (y[WORD_W-1])
      y = y + {1'b0, mod_m};
    return y;
  endfunction

  function automatic logic [VAL_W-1:0] mod_alu_result(input logic [2:0] mode,
                                                      input logic [VAL_W-1:0] a,
                                                      input logic [VAL_W-1:0] b);
    logic [WORD_W-1:0] aw;
    logic [WORD_W-1:0] bw;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] r;
    aw = {1'b0, a};
    bw = {1'b0, b};
    m  = {1'b0, mod_m};
    case (mode)
      mma_pkg::MODE_ADD: begin
        r = aw + (bw - m);
        if (r[WORD_W-1])
          r = r + m;
      end
      mma_pkg::MODE_SUB: begin
        r = aw - bw;
        if (r[WORD_W-1])
          r = r + m;
      end
      mma_pkg::MODE_MUL:       r = redc_value({64'd0, aw} * {64'd0, bw});
      mma_pkg::MODE_TO_MONT:   r = redc_value({64'd0, aw} * {65'd0, mod_r2});
      mma_pkg::MODE_FROM_MONT: r = redc_value({64'd0, aw});
      default:                 r = '0;   // spare modes read as zero
    endcase
    return r[VAL_W-1:0];
  endfunction

  // m^-1 mod 2^64 by Newton steps; each one doubles the correct low bits.
  function automatic logic [WORD_W-1:0] inverse_mod_r(input logic [VAL_W-1:0] m);
    logic [WORD_W-1:0] mw;
    logic [WORD_W-1:0] x;
    mw = {1'b0, m};
    x  = mw;
    repeat (6)
      x = x * (64'd2 - mw * x);
    return x;
  endfunction

  function automatic logic [VAL_W-1:0] r_squared_mod(input logic [VAL_W-1:0] m);
    logic [2*WORD_W:0] full;
    full = {1'b1, 128'd0} % {66'd0, m};
    return full[VAL_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly operands below m; now and then the top value, m-1 or full-width noise.
  function automatic logic [VAL_W-1:0] rand_operand();
    int unsigned pick;
    logic [WORD_W-1:0] v;
    pick = $urandom_range(0, 19);
    if (pick < 14)
      v = rand64() % {1'b0, mod_m};
    else if (pick < 16)
      v = {1'b0, mod_m} - 64'd1;
    else if (pick == 16)
      v = {1'b0, ALL_ONES};
    else
      v = rand64();
    return v[VAL_W-1:0];
  endfunction

  function automatic alu_req_t random_req();
    alu_req_t req;
    if ($urandom_range(0, 19) < 18)
      req.mode = 3'($urandom_range(mma_pkg::MODE_ADD, mma_pkg::MODE_FROM_MONT));
    else
      req.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    req.a = rand_operand();
    req.b = rand_operand();
    return req;
  endfunction

  task automatic queue_req(input logic [2:0] mode, input logic [VAL_W-1:0] a,
                           input logic [VAL_W-1:0] b);
    pending_reqs.push_back('{mode: mode, a: a, b: b});
  endtask

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Proper setting for an odd modulus; top_bit lands in bit 63 of the write and must be dropped.
  task automatic load_modulus(input logic [VAL_W-1:0] m, input logic top_bit);
    cfg_write(mma_pkg::REG_MODULUS, {top_bit, m});
    cfg_write(mma_pkg::REG_MOD_INV, inverse_mod_r(m));
    cfg_write(mma_pkg::REG_R_SQUARED, {1'b0, r_squared_mod(m)});
  endtask

  // Register copy follows the write port; unknown indexes are dropped.
  always @(posedge clk) begin
    if (!rst_n) begin
      mod_m   <= VAL_W'(1);
      mod_inv <= WORD_W'(1);
      mod_r2  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mma_pkg::REG_MODULUS:   mod_m   <= cfg_wdata[VAL_W-1:0];
        mma_pkg::REG_MOD_INV:   mod_inv <= cfg_wdata;
        mma_pkg::REG_R_SQUARED: mod_r2  <= cfg_wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: one request per handshake, with random gaps of idle cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alu_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 16);
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        in_valid     <= 1'b1;
        in_mode      <= req.mode;
        in_operand_a <= req.a;
        in_operand_b <= req.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accepted request: predict now, with the registers as they stand
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      due_results.push_back(mod_alu_result(in_mode, in_operand_a, in_operand_b));
  end

  // ---------------------------------------------------------------------------
  // Result side: stall bursts and in-order check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result: expected none, got %h", out_result);
        faults++;
      end else begin
        want = due_results.pop_front();
        if (out_result !== want) begin
          $error("result: expected %h, got %h", want, out_result);
          faults++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  // Block is idle once nothing is queued, offered or owed; every request
  // yields a result, so an empty owed list means the pipe is empty.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  task automatic random_phase(input int count, input int unsigned odds);
    @(negedge clk);   // register copy settles after the last write
    burst_odds = odds;
    repeat (count)
      pending_reqs.push_back(random_req());
    wait_drained();
  endtask

  initial begin
    logic [VAL_W-1:0] m;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: m = 1, so every sound result is zero
    random_phase(20, 6);

    // Largest modulus, directed corners
    load_modulus(ALL_ONES, 1'b0);
    @(negedge clk);
    burst_odds = 5;
    queue_req(mma_pkg::MODE_ADD, '0, '0);
    queue_req(mma_pkg::MODE_ADD, mod_m - 1, mod_m - 1);
    queue_req(mma_pkg::MODE_ADD, mod_m - 1, 1);                // wraps to zero
    queue_req(mma_pkg::MODE_ADD, ALL_ONES, ALL_ONES);          // operands not reduced
    queue_req(mma_pkg::MODE_SUB, '0, mod_m - 1);               // borrow, +m fix-up
    queue_req(mma_pkg::MODE_SUB, mod_m - 1, '0);
    queue_req(mma_pkg::MODE_SUB, 5, 5);
    queue_req(mma_pkg::MODE_MUL, mod_m - 1, mod_m - 1);
    queue_req(mma_pkg::MODE_MUL, '0, mod_m - 1);
    queue_req(mma_pkg::MODE_MUL, 1, 1);
    queue_req(mma_pkg::MODE_MUL, ALL_ONES, ALL_ONES);
    queue_req(mma_pkg::MODE_TO_MONT, '0, ALL_ONES);            // b ignored
    queue_req(mma_pkg::MODE_TO_MONT, mod_m - 1, '0);
    queue_req(mma_pkg::MODE_TO_MONT, 1, 1);
    queue_req(mma_pkg::MODE_FROM_MONT, 1, ALL_ONES);
    queue_req(mma_pkg::MODE_FROM_MONT, mod_m - 1, '0);
    queue_req(mma_pkg::MODE_FROM_MONT, '0, '0);
    queue_req(MODE_SPARE_FIRST, ALL_ONES, ALL_ONES);  // spare modes give zero
    queue_req(MODE_SPARE_MID, ALL_ONES, ALL_ONES);
    queue_req(MODE_SPARE_LAST, ALL_ONES, '0);
    wait_drained();
    random_phase(60, 0);

    // Smallest non-trivial modulus
    load_modulus(3, 1'b0);
    random_phase(55, 4);

    // Wide random odd modulus, bit 63 set in the write data
    m = VAL_W'(rand64());
    load_modulus(m | 1, 1'b1);
    random_phase(60, 12);

    // Narrow random odd modulus
    m = {31'd0, $urandom} | VAL_W'(1);
    load_modulus(m, 1'b0);
    random_phase(55, 3);

    // Broken setting: even modulus, junk inverse and R^2, write to the spare slot
    cfg_write(mma_pkg::REG_MODULUS, (rand64() | 64'd2) & ~64'd1);
    cfg_write(mma_pkg::REG_MOD_INV, rand64());
    cfg_write(mma_pkg::REG_R_SQUARED, rand64() | {1'b1, 63'd0});
    cfg_write(REG_SPARE, rand64());
    random_phase(50, 8);

    // Register extremes: zero inverse, top R^2
    m = VAL_W'(rand64());
    load_modulus(m | 1, 1'b0);
    cfg_write(mma_pkg::REG_MOD_INV, '0);
    cfg_write(mma_pkg::REG_R_SQUARED, {WORD_W{1'b1}});
    random_phase(45, 6);

    // m = 1 with an all-ones inverse
    load_modulus(1, 1'b0);
    cfg_write(mma_pkg::REG_MOD_INV, {WORD_W{1'b1}});
    random_phase(30, 10);

    // Closing stretch at full rate
    m = VAL_W'(rand64());
    load_modulus(m | 1, 1'b0);
    random_phase(60, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("result: %0d still owed at end", due_results.size());
      faults++;
    end
    if (faults == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
